FILE: rtl/assert_macros.svh
// Assertion helpers for the skeleton tip and branch detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_ALWAYS(label, clk, rst_n, cond)

`endif

`endif

FILE: rtl/stbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stbd_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);

    localparam int CFG_WIDTH_W  = 12;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W   = 13;

    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [1:0] KIND_TIP    = 2'd0;
    localparam logic [1:0] KIND_BRANCH = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    typedef struct packed {
        logic [1:0]    kind;
        logic [XW-1:0] pos_x;
        logic [YW-1:0] pos_y;
        logic [3:0]    neighbor_count;
    } result_t;

    typedef struct packed {
        logic [1:0] num;
        result_t    first;
        result_t    second;
    } push_t;

    typedef struct packed {
        logic          en;
        logic [XW-1:0] addr;
    } line_rd_t;

    typedef struct packed {
        logic          en;
        logic [XW-1:0] addr;
        logic [1:0]    data;
    } line_wr_t;

    typedef struct packed {
        logic [FIFO_AW:0] count;
    } fifo_status_t;

    function automatic logic [XW:0] clamp_width(input logic [CFG_WIDTH_W-1:0] v);
        logic [XW:0] r;
        if (32'(v) < 3) begin
            r = (XW+1)'(3);
        end else if (32'(v) > MAX_WIDTH) begin
            r = (XW+1)'(MAX_WIDTH);
        end else begin
            r = (XW+1)'(v);
        end
        return r;
    endfunction

    function automatic logic [YW:0] clamp_height(input logic [CFG_HEIGHT_W-1:0] v);
        logic [YW:0] r;
        if (32'(v) < 3) begin
            r = (YW+1)'(3);
        end else if (32'(v) > MAX_HEIGHT) begin
            r = (YW+1)'(MAX_HEIGHT);
        end else begin
            r = (YW+1)'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/skeleton_tip_branch_detect.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Skeleton tip and branch point detector. Pixels stream in raster order, one
// per transfer, and a transfer is taken every clock while the result queue has
// room; each pixel passes the line store read, then classify and write back,
// and its report is registered into the result queue from the classify step.
// The previous two rows live in one 2-bit-wide synchronous line memory of
// MAX_WIDTH entries, read once and written once per pixel. A
// report for the window centre (x-1, y-1) carries kind 0 (tip, one neighbor)
// or 1 (branch, three or more), and the frame's last pixel adds a kind 2
// end-of-frame transfer. Width and height are clamped to 3..MAX on write and
// must only be changed while the block is idle. Results wait in an 8-entry
// queue; input stalls when fewer than four free entries remain for the
// pixels in flight.
module skeleton_tip_branch_detect (
    input  wire                                 aclk,
    input  wire                                 aresetn,

    input  wire                                 cfg_we,
    input  wire                                 cfg_index,
    input  wire [stbd_pkg::CFG_DATA_W-1:0]      cfg_wdata,

    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire [7:0]                           s_axis_tdata,   // pixel[7:0]

    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic [31:0]                         m_axis_tdata,   // pos_x, pos_y, neighbor_count, zero pad
    output logic [1:0]                          m_axis_tuser    // kind
);
    import stbd_pkg::*;

    line_rd_t     line_rd;
    line_wr_t     line_wr;
    logic [1:0]   line_rd_data;
    logic         busy;
    push_t        push;
    result_t      head;
    fifo_status_t fifo_status;
    logic         in_accept;
    logic [FIFO_AW+1:0] committed;

    assign committed     = (FIFO_AW+2)'(fifo_status.count) + (busy ? (FIFO_AW+2)'(2) : '0);
    assign s_axis_tready = committed <= (FIFO_AW+2)'(FIFO_DEPTH - 4);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    stbd_line_mem u_line_mem (
        .aclk    (aclk),
        .rd      (line_rd),
        .wr      (line_wr),
        .rd_data (line_rd_data)
    );

    stbd_scan u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_accept    (in_accept),
        .pixel        (s_axis_tdata),
        .line_rd      (line_rd),
        .line_wr      (line_wr),
        .line_rd_data (line_rd_data),
        .busy         (busy),
        .push         (push)
    );

    stbd_result_fifo u_result_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (head),
        .status    (fifo_status)
    );

    assign m_axis_tuser = head.kind;
    assign m_axis_tdata = 32'({head.neighbor_count, head.pos_y, head.pos_x});

    `ASSERT_ALWAYS(a_fifo_bound, aclk, aresetn, fifo_status.count <= (FIFO_AW+1)'(FIFO_DEPTH))
    `ASSERT_IMPLIES(a_end_zero, aclk, aresetn, m_axis_tvalid && (m_axis_tuser == KIND_END), m_axis_tdata == 32'd0)
    `ASSERT_IMPLIES(a_tip_one, aclk, aresetn, m_axis_tvalid && (m_axis_tuser == KIND_TIP), head.neighbor_count == 4'd1)
    `ASSERT_IMPLIES(a_kind_legal, aclk, aresetn, m_axis_tvalid, (m_axis_tuser == KIND_TIP) || (m_axis_tuser == KIND_BRANCH) || (m_axis_tuser == KIND_END))

endmodule

`default_nettype wire

FILE: rtl/stbd_line_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module stbd_line_mem (
    input  wire                   aclk,
    input  stbd_pkg::line_rd_t    rd,
    input  stbd_pkg::line_wr_t    wr,
    output logic [1:0]            rd_data
);
    import stbd_pkg::*;

    // entry holds {middle row bit, upper row bit}
    logic [1:0] mem [MAX_WIDTH];
    logic [1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/stbd_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module stbd_scan (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 cfg_we,
    input  wire                                 cfg_index,
    input  wire [stbd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  wire                                 in_accept,
    input  wire [7:0]                           pixel,
    output stbd_pkg::line_rd_t                  line_rd,
    output stbd_pkg::line_wr_t                  line_wr,
    input  wire [1:0]                           line_rd_data,
    output logic                                busy,
    output stbd_pkg::push_t                     push
);
    import stbd_pkg::*;

    function automatic logic [3:0] bits3(input logic [2:0] c);
        return 4'(c[0]) + 4'(c[1]) + 4'(c[2]);
    endfunction

    logic [XW:0]   width_reg;
    logic [YW:0]   height_reg;
    logic [XW-1:0] col_reg, col_next;
    logic [YW-1:0] row_reg, row_next;
    logic          last_col, last_row;

    logic          s1_valid_reg;
    logic          s1_cur_reg;
    logic          s1_end_reg;
    logic [XW-1:0] s1_x_reg;
    logic [YW-1:0] s1_y_reg;
    logic [5:0]    win_reg;

    logic [2:0]    cola, colb, colc;
    logic [3:0]    ncount;
    logic          interior;
    logic          is_tip, is_branch;
    result_t       report, frame_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= (XW+1)'(RESET_WIDTH);
            height_reg <= (YW+1)'(RESET_HEIGHT);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_IDX_WIDTH:  width_reg  <= clamp_width(cfg_wdata[CFG_WIDTH_W-1:0]);
                CFG_IDX_HEIGHT: height_reg <= clamp_height(cfg_wdata[CFG_HEIGHT_W-1:0]);
                default: ;
            endcase
        end
    end

    assign last_col = ({1'b0, col_reg} + (XW+1)'(1)) >= width_reg;
    assign last_row = ({1'b0, row_reg} + (YW+1)'(1)) >= height_reg;

    always_comb begin
        col_next = col_reg + XW'(1);
        row_next = row_reg;
        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + YW'(1);
        end
    end

    // stage 0: advance position and issue the line store read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_accept;
            if (in_accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_cur_reg <= |pixel;
            s1_end_reg <= last_col && last_row;
            s1_x_reg   <= col_reg;
            s1_y_reg   <= row_reg;
        end
    end

    assign line_rd.en   = in_accept;
    assign line_rd.addr = col_reg;

    // stage 1: window update, classify, write back
    assign colc = {s1_cur_reg, line_rd_data[1], line_rd_data[0]};
    assign colb = win_reg[2:0];
    assign cola = win_reg[5:3];

    assign ncount   = bits3(cola) + bits3(colc) + 4'(colb[0]) + 4'(colb[2]);
    assign interior = (32'(s1_x_reg) >= 2) && (32'(s1_y_reg) >= 2) && colb[1];
    assign is_tip    = interior && (ncount == 4'd1);
    assign is_branch = interior && (ncount >= 4'd3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (s1_valid_reg) begin
            win_reg <= {colb, colc};
        end
    end

    assign line_wr.en   = s1_valid_reg;
    assign line_wr.addr = s1_x_reg;
    assign line_wr.data = {s1_cur_reg, line_rd_data[1]};

    always_comb begin
        report.kind           = is_tip ? KIND_TIP : KIND_BRANCH;
        report.pos_x          = s1_x_reg - XW'(1);
        report.pos_y          = s1_y_reg - YW'(1);
        report.neighbor_count = ncount;

        frame_end.kind           = KIND_END;
        frame_end.pos_x          = '0;
        frame_end.pos_y          = '0;
        frame_end.neighbor_count = '0;

        push.num    = 2'd0;
        push.first  = report;
        push.second = frame_end;
        if (s1_valid_reg) begin
            if (is_tip || is_branch) begin
                push.num = s1_end_reg ? 2'd2 : 2'd1;
            end else if (s1_end_reg) begin
                push.num   = 2'd1;
                push.first = frame_end;
            end
        end
    end

    assign busy = s1_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/stbd_result_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module stbd_result_fifo (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  stbd_pkg::push_t             push,
    output logic                        out_valid,
    input  wire                         out_ready,
    output stbd_pkg::result_t           out_data,
    output stbd_pkg::fifo_status_t      status
);
    import stbd_pkg::*;

    result_t            slot_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    assign wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.num);
    assign count_next  = count_reg + (FIFO_AW+1)'(push.num) - (FIFO_AW+1)'(pop);

    always_ff @(posedge aclk) begin
        if (push.num != 2'd0) begin
            slot_reg[wr_ptr_reg] <= push.first;
        end
        if (push.num == 2'd2) begin
            slot_reg[wr_ptr_reg + FIFO_AW'(1)] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
        end
    end

    assign status.count = count_reg;

endmodule

`default_nettype wire

FILE: test/tip_branch_checker.sv
`timescale 1ns / 1ps

module tip_branch_checker (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             cfg_we,
    input  wire                             cfg_index,
    input  wire [stbd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire                             s_axis_tvalid,
    input  wire                             s_axis_tready,
    input  wire [7:0]                       s_axis_tdata,
    input  wire                             m_axis_tvalid,
    input  wire                             m_axis_tready,
    input  wire [31:0]                      m_axis_tdata,
    input  wire [1:0]                       m_axis_tuser,
    output int                              fail_count,
    output int                              pending,
    output int                              tips_seen,
    output int                              branches_seen,
    output int                              frames_seen
);
    import stbd_pkg::*;

    result_t                 due_reports[$];
    bit                      upper_row [MAX_WIDTH];
    bit                      middle_row [MAX_WIDTH];
    logic [5:0]              window;
    int                      col;
    int                      row;
    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;

    function automatic int bound(input int v, input int hi);
        if (v < 3) begin
            return 3;
        end
        return (v > hi) ? hi : v;
    endfunction

    function automatic int ones3(input logic [2:0] c);
        return int'(c[0]) + int'(c[1]) + int'(c[2]);
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH at %0t: %s got %0d, want %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic void queue_report(input logic [1:0] kind, input int x, input int y,
                                         input int n);
        result_t r;
        r.kind           = kind;
        r.pos_x          = XW'(x);
        r.pos_y          = YW'(y);
        r.neighbor_count = 4'(n);
        due_reports = {due_reports, r};
    endfunction

    task automatic classify_pixel(input logic [7:0] value);
        int         w;
        int         h;
        int         n;
        int         xi;
        logic [2:0] colc;
        logic [2:0] colb;
        logic [2:0] cola;
        w    = bound(int'(width_reg), MAX_WIDTH);
        h    = bound(int'(height_reg), MAX_HEIGHT);
        xi   = col % MAX_WIDTH;
        colc = {value != 8'd0, middle_row[xi], upper_row[xi]};
        colb = window[2:0];
        cola = window[5:3];
        upper_row[xi]  = colc[1];
        middle_row[xi] = colc[2];
        if (col >= 2 && row >= 2 && colb[1]) begin
            n = ones3(cola) + ones3(colc) + int'(colb[0]) + int'(colb[2]);
            if (n == 1) begin
                queue_report(KIND_TIP, col - 1, row - 1, n);
            end else if (n >= 3) begin
                queue_report(KIND_BRANCH, col - 1, row - 1, n);
            end
        end
        window = {colb, colc};
        if (col + 1 >= w) begin
            col = 0;
            if (row + 1 >= h) begin
                row = 0;
                queue_report(KIND_END, 0, 0, 0);
            end else begin
                row++;
            end
        end else begin
            col++;
        end
    endtask

    task automatic check_transfer();
        result_t     want;
        logic [1:0]  kind;
        logic [XW-1:0] px;
        logic [YW-1:0] py;
        logic [3:0]  cnt;
        logic [31-XW-YW-4:0] pad;
        kind = m_axis_tuser;
        px   = m_axis_tdata[XW-1:0];
        py   = m_axis_tdata[XW+YW-1:XW];
        cnt  = m_axis_tdata[XW+YW+3:XW+YW];
        pad  = m_axis_tdata[31:XW+YW+4];
        if (due_reports.size() == 0) begin
            flag_mismatch("unexpected transfer, kind", 32'(kind), 32'd0);
            return;
        end
        want = due_reports.pop_front();
        if (kind !== want.kind) flag_mismatch("kind", 32'(kind), 32'(want.kind));
        if (px !== want.pos_x) flag_mismatch("pos_x", 32'(px), 32'(want.pos_x));
        if (py !== want.pos_y) flag_mismatch("pos_y", 32'(py), 32'(want.pos_y));
        if (cnt !== want.neighbor_count) begin
            flag_mismatch("neighbor_count", 32'(cnt), 32'(want.neighbor_count));
        end
        if (pad !== '0) flag_mismatch("tdata padding", 32'(pad), 32'd0);
        case (want.kind)
            KIND_TIP:    tips_seen++;
            KIND_BRANCH: branches_seen++;
            default:     frames_seen++;
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            due_reports.delete();
            foreach (upper_row[i]) begin
                upper_row[i]  = 1'b0;
                middle_row[i] = 1'b0;
            end
            window        = '0;
            col           = 0;
            row           = 0;
            width_reg     = CFG_WIDTH_W'(RESET_WIDTH);
            height_reg    = CFG_HEIGHT_W'(RESET_HEIGHT);
            fail_count    = 0;
            tips_seen     = 0;
            branches_seen = 0;
            frames_seen   = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_IDX_WIDTH) begin
                    width_reg = cfg_wdata[CFG_WIDTH_W-1:0];
                end else begin
                    height_reg = cfg_wdata[CFG_HEIGHT_W-1:0];
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                classify_pixel(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                check_transfer();
            end
        end
        pending = due_reports.size();
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import stbd_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 1000;

    // opening frames, pixel 0 in the lowest byte
    localparam logic [71:0] ALL_SET   = {8'd128, 8'd64, 8'd32, 8'd16, 8'd8,
                                         8'd4, 8'd2, 8'd1, 8'd255};
    localparam logic [71:0] ONE_TIP   = {8'd77, 8'd0, 8'd0, 8'd0, 8'd200,
                                         8'd0, 8'd0, 8'd0, 8'd0};
    localparam logic [71:0] TWO_NEIGH = {8'd0, 8'd0, 8'd0, 8'd0, 8'd1,
                                         8'd3, 8'd0, 8'd9, 8'd0};

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [31:0]           m_axis_tdata;
    logic [1:0]            m_axis_tuser;

    int fail_count;
    int pending;
    int tips_seen;
    int branches_seen;
    int frames_seen;

    bit hold_req = 1'b0;
    bit gaps_on  = 1'b0;
    int burst_left = 0;
    int pixels_sent = 0;
    int settings_used = 0;
    bit img[];

    always #6 aclk = ~aclk;

    skeleton_tip_branch_detect DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    tip_branch_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending),
        .tips_seen     (tips_seen),
        .branches_seen (branches_seen),
        .frames_seen   (frames_seen)
    );

    task automatic offer_pixel(input logic [7:0] value);
        int gap;
        bit taken;
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
                if (gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            burst_left--;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        taken = 1'b0;
        while (!taken) begin
            @(posedge aclk);
            taken = s_axis_tready;
            @(negedge aclk);
        end
        pixels_sent++;
    endtask

    function automatic logic [7:0] random_pixel(input int dens);
        return ($urandom_range(1, 100) <= dens) ? 8'($urandom_range(1, 255)) : 8'd0;
    endfunction

    task automatic send_block(input logic [71:0] blk);
        for (int i = 0; i < 9; i++) begin
            offer_pixel(blk[8*i +: 8]);
        end
    endtask

    // dens < 0 draws skeleton-like strokes, otherwise uniform noise
    task automatic build_frame(input int w, input int h, input int dens);
        int strokes;
        int px;
        int py;
        int dx;
        int dy;
        int steps;
        img = new[w * h];
        if (dens >= 0) begin
            foreach (img[i]) img[i] = ($urandom_range(1, 100) <= dens);
        end else begin
            foreach (img[i]) img[i] = 1'b0;
            strokes = $urandom_range(1, 5);
            repeat (strokes) begin
                px    = $urandom_range(0, w - 1);
                py    = $urandom_range(0, h - 1);
                dx    = int'($urandom_range(0, 2)) - 1;
                dy    = int'($urandom_range(0, 2)) - 1;
                steps = $urandom_range(2, w + h);
                repeat (steps) begin
                    img[py * w + px] = 1'b1;
                    if ($urandom_range(0, 3) == 0) begin
                        dx = int'($urandom_range(0, 2)) - 1;
                        dy = int'($urandom_range(0, 2)) - 1;
                    end
                    px = px + dx;
                    py = py + dy;
                    if (px < 0) px = 0;
                    if (px > w - 1) px = w - 1;
                    if (py < 0) py = 0;
                    if (py > h - 1) py = h - 1;
                end
            end
        end
    endtask

    task automatic send_frame();
        foreach (img[i]) begin
            offer_pixel(img[i] ? 8'($urandom_range(1, 255)) : 8'd0);
        end
    endtask

    // drop valid, wait for every report, then let in-flight pixels retire
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        wait (pending == 0);
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_dims(input int w_raw, input int h_raw);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_WIDTH;
        cfg_wdata <= CFG_DATA_W'(w_raw);
        @(negedge aclk);
        cfg_index <= CFG_IDX_HEIGHT;
        cfg_wdata <= CFG_DATA_W'(h_raw);
        @(negedge aclk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic int raw_of(input int eff);
        if (eff == 3 && $urandom_range(0, 1) == 1) begin
            return $urandom_range(0, 3);
        end
        return eff;
    endfunction

    initial begin : result_sink
        int         tick;
        int         mode;
        logic [15:0] pat;
        tick = 0;
        mode = 0;
        pat  = '1;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            if (tick % 64 == 0) begin
                mode = $urandom_range(0, 3);
                pat  = 16'($urandom);
            end
            case (mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
                2:       m_axis_tready <= pat[tick % 16];
                default: m_axis_tready <= ($urandom_range(0, 7) != 0);
            endcase
            tick++;
        end
    end

    initial begin : watchdog
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int w;
        int h;
        int dens;
        int phase;
        int cut_row;
        int cut_col;
        int new_w;
        int new_h;
        int remain;
        int target;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_IDX_WIDTH;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        set_dims(3, 3);
        send_block(ALL_SET);
        send_block(ONE_TIP);
        settle();
        set_dims(1, 2);
        send_block(TWO_NEIGH);
        settle();

        target = pixels_sent + RANDOM_ITEMS;
        phase  = 0;
        while (pixels_sent < target) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if (phase % 7 == 1) begin
                // resize in the middle of a frame
                w    = $urandom_range(6, 16);
                h    = $urandom_range(5, 10);
                dens = $urandom_range(10, 70);
                set_dims(w, h);
                cut_row = $urandom_range(2, h - 2);
                cut_col = $urandom_range(0, w - 1);
                repeat (cut_row * w + cut_col) offer_pixel(random_pixel(dens));
                settle();
                new_w = $urandom_range(3, w);
                new_h = $urandom_range(3, h);
                set_dims(raw_of(new_w), raw_of(new_h));
                remain = (cut_col >= new_w) ? 1 : new_w - cut_col;
                if (cut_row + 1 < new_h) begin
                    remain += (new_h - cut_row - 1) * new_w;
                end
                repeat (remain) offer_pixel(random_pixel(dens));
                settle();
            end else begin
                if (phase == 0) begin
                    w        = 16;
                    h        = 12;
                    dens     = 55;
                    gaps_on  = 1'b0;
                    hold_req = 1'b1;
                end else begin
                    w    = ($urandom_range(0, 5) == 0) ? $urandom_range(21, 64)
                                                       : $urandom_range(3, 20);
                    h    = $urandom_range(3, 12);
                    dens = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 100) : -1;
                end
                set_dims(raw_of(w), raw_of(h));
                repeat ($urandom_range(1, 3)) begin
                    build_frame(w, h, dens);
                    send_frame();
                end
                settle();
            end
            phase++;
        end

        // oversized settings, then narrow down to close the frame
        gaps_on = 1'b1;
        set_dims(4095, 8191);
        repeat (30) offer_pixel(random_pixel(60));
        settle();
        set_dims(3, 3);
        repeat (7) offer_pixel(random_pixel(60));
        settle();

        $display("Covered %0d pixels over %0d size settings, including mid-frame resizing",
                 pixels_sent, settings_used);
        $display("Checked %0d tip, %0d branch and %0d end-of-frame transfers",
                 tips_seen, branches_seen, frames_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/stbd_pkg.sv
rtl/stbd_line_mem.sv
rtl/stbd_scan.sv
rtl/stbd_result_fifo.sv
rtl/skeleton_tip_branch_detect.sv
test/tip_branch_checker.sv
test/testbench.sv
